@@ sv/shell_token_lexer_core_defines.svh @@
// Assertion macros shared by the shell token lexer RTL.
`ifndef SHELL_TOKEN_LEXER_CORE_DEFINES_SVH
`define SHELL_TOKEN_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHTL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/shtl_pkg.sv @@
// Types and constants shared by the shell token lexer modules.
package shtl_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam logic [FIELD_W-1:0] LEN_MAX = '1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;

	typedef enum logic [2:0] {
		TK_WORD   = 3'd0,
		TK_SEMI   = 3'd1,
		TK_LPAREN = 3'd2,
		TK_RPAREN = 3'd3,
		TK_ANDAND = 3'd4,
		TK_OROR   = 3'd5,
		TK_END    = 3'd6,
		TK_BAD    = 3'd7
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} src_word_t;

	typedef struct packed {
		tok_kind_t          token_kind;
		logic [FIELD_W-1:0] token_pos;
		logic [FIELD_W-1:0] token_length;
		logic               last_of_item;
	} tok_word_t;

	// Tokens produced by one source byte: up to two, tok0 first.
	typedef struct packed {
		logic [1:0] count;
		tok_word_t  tok0;
		tok_word_t  tok1;
	} lex_res_t;

endpackage

@@ sv/shtl_lex.sv @@
// Lexer state and per-byte token decode.
`include "shell_token_lexer_core_defines.svh"

module shtl_lex #(
	parameter int unsigned POS_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  shtl_pkg::src_word_t item,
	output shtl_pkg::lex_res_t  res
);

	localparam int unsigned LW = (POS_WIDTH > shtl_pkg::FIELD_W) ? POS_WIDTH : shtl_pkg::FIELD_W;
	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_WORD = 3'd1,
		M_AMP  = 3'd2,
		M_PIPE = 3'd3,
		M_HALT = 3'd4
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d, pos_inc;
	logic [POS_WIDTH-1:0] beg_q, beg_d;
	logic                 fin, is_ws, is_punct, word_byte, open_tok, st_emit;
	shtl_pkg::tok_kind_t  punct_kind;
	shtl_pkg::tok_word_t  st_tok;
	logic [7:0]           b;

	function automatic logic [shtl_pkg::FIELD_W-1:0] pos_lo(input logic [POS_WIDTH-1:0] p);
		logic [LW-1:0] x;
		x = LW'(p);
		return x[shtl_pkg::FIELD_W-1:0];
	endfunction

	// Length from start to stop, clamped to the field.
	function automatic logic [shtl_pkg::FIELD_W-1:0] span(input logic [POS_WIDTH-1:0] a,
			input logic [POS_WIDTH-1:0] z);
		logic [POS_WIDTH-1:0] d;
		logic [LW-1:0]        dx;
		d  = (z > a) ? z - a : '0;
		dx = LW'(d);
		if ((dx >> shtl_pkg::FIELD_W) != '0) begin
			return shtl_pkg::LEN_MAX;
		end
		return dx[shtl_pkg::FIELD_W-1:0];
	endfunction

	function automatic shtl_pkg::tok_word_t mk(input shtl_pkg::tok_kind_t k,
			input logic [shtl_pkg::FIELD_W-1:0] s, input logic [shtl_pkg::FIELD_W-1:0] n);
		shtl_pkg::tok_word_t t;
		t.token_kind   = k;
		t.token_pos    = s;
		t.token_length = n;
		t.last_of_item = 1'b0;
		return t;
	endfunction

	assign b        = item.ch;
	assign fin      = item.end_of_source || (b == shtl_pkg::CH_NUL);
	assign is_ws    = (b == shtl_pkg::CH_SPACE) || ((b >= shtl_pkg::CH_TAB) && (b <= shtl_pkg::CH_CR));
	assign is_punct = (b == shtl_pkg::CH_SEMI) || (b == shtl_pkg::CH_LPAREN) ||
		(b == shtl_pkg::CH_RPAREN);
	assign word_byte = !fin && !is_ws && !is_punct && (b != shtl_pkg::CH_AMP) &&
		(b != shtl_pkg::CH_PIPE);
	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_WIDTH'(1);

	always_comb begin
		priority if (b == shtl_pkg::CH_SEMI) begin
			punct_kind = shtl_pkg::TK_SEMI;
		end else if (b == shtl_pkg::CH_LPAREN) begin
			punct_kind = shtl_pkg::TK_LPAREN;
		end else begin
			punct_kind = shtl_pkg::TK_RPAREN;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		beg_d    = beg_q;
		res      = '0;
		open_tok = 1'b0;
		st_emit  = 1'b0;
		st_tok   = '0;

		unique case (mode_q)
			M_HALT: begin
				if (fin) begin
					mode_d = M_IDLE;
					pos_d  = '0;
					beg_d  = '0;
				end
			end
			M_WORD: begin
				if (word_byte) begin
					pos_d = pos_inc;
				end else begin
					res.tok0  = mk(shtl_pkg::TK_WORD, pos_lo(beg_q), span(beg_q, pos_q));
					res.count = 2'd1;
					mode_d    = M_IDLE;
					open_tok  = 1'b1;
				end
			end
			M_AMP, M_PIPE: begin
				if (!fin && (b == ((mode_q == M_AMP) ? shtl_pkg::CH_AMP : shtl_pkg::CH_PIPE))) begin
					pos_d     = pos_inc;
					res.tok0  = mk((mode_q == M_AMP) ? shtl_pkg::TK_ANDAND : shtl_pkg::TK_OROR,
						pos_lo(beg_q), span(beg_q, pos_inc));
					res.count = 2'd1;
					mode_d    = M_IDLE;
				end else begin
					res.tok0  = mk(shtl_pkg::TK_BAD, pos_lo(beg_q), shtl_pkg::FIELD_W'(1));
					res.count = 2'd1;
					if (fin) begin
						mode_d = M_IDLE;
						pos_d  = '0;
						beg_d  = '0;
					end else begin
						mode_d = M_HALT;
					end
				end
			end
			default: begin
				mode_d   = M_IDLE;
				open_tok = 1'b1;
			end
		endcase

		// Start a new token with the current byte.
		if (open_tok) begin
			priority if (fin) begin
				st_emit = 1'b1;
				st_tok  = mk(shtl_pkg::TK_END, pos_lo(pos_q), '0);
				mode_d  = M_IDLE;
				pos_d   = '0;
				beg_d   = '0;
			end else if (is_ws) begin
				pos_d = pos_inc;
			end else if (is_punct) begin
				st_emit = 1'b1;
				st_tok  = mk(punct_kind, pos_lo(pos_q),
					(pos_q != POS_MAX) ? shtl_pkg::FIELD_W'(1) : '0);
				pos_d   = pos_inc;
			end else if ((b == shtl_pkg::CH_AMP) || (b == shtl_pkg::CH_PIPE)) begin
				beg_d  = pos_q;
				mode_d = (b == shtl_pkg::CH_AMP) ? M_AMP : M_PIPE;
				pos_d  = pos_inc;
			end else begin
				beg_d  = pos_q;
				mode_d = M_WORD;
				pos_d  = pos_inc;
			end
			if (st_emit) begin
				if (res.count == 2'd0) begin
					res.tok0 = st_tok;
				end else begin
					res.tok1 = st_tok;
				end
				res.count = res.count + 2'd1;
			end
		end

		if (res.count == 2'd1) begin
			res.tok0.last_of_item = 1'b1;
		end
		if (res.count == 2'd2) begin
			res.tok1.last_of_item = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
		end else if (go) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			beg_q  <= beg_d;
		end
	end

	`SHTL_ASSERT_NOW(a_lex_pair_word_first, go && (res.count == 2'd2),
		res.tok0.token_kind == shtl_pkg::TK_WORD, "two tokens without a closing word")
	`SHTL_ASSERT_NOW(a_lex_halt_quiet, go && (mode_q == M_HALT), res.count == 2'd0,
		"token emitted while halted")
	`SHTL_ASSERT_NEXT(a_lex_bad_halts,
		go && (res.count != 2'd0) && (res.tok0.token_kind == shtl_pkg::TK_BAD),
		(mode_q == M_HALT) || (mode_q == M_IDLE), "bad token did not halt or restart")

endmodule

@@ sv/shtl_outq.sv @@
// Four-entry token queue between the lexer and the output channel.
`include "shell_token_lexer_core_defines.svh"

module shtl_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  shtl_pkg::lex_res_t  push,
	output logic                room,
	output logic                tok_valid,
	input  logic                tok_stall,
	output shtl_pkg::tok_word_t tok_word
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	shtl_pkg::tok_word_t mem_q [DEPTH];
	logic [AW-1:0]       wr_q, rd_q;
	logic [CW-1:0]       cnt_q;
	logic                pop;

	assign tok_valid = (cnt_q != '0);
	assign tok_word  = mem_q[rd_q];
	assign pop       = tok_valid && !tok_stall;
	// Room for a full pair of tokens.
	assign room      = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + AW'(1)] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.count);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

	`SHTL_ASSERT_NOW(a_outq_no_overflow, push.count != 2'd0, room,
		"tokens pushed without room")
	`SHTL_ASSERT_NEXT(a_outq_drain, pop && (push.count == 2'd0),
		cnt_q == $past(cnt_q) - CW'(1), "pop did not drain one entry")

endmodule

@@ sv/shell_token_lexer_core.sv @@
// Top level of the streaming shell token lexer.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------
//   src     | in        | src_valid/src_stall| one source byte + end mark
//   tok     | out       | tok_valid/tok_stall| one token: kind, start, length
//
// A byte is taken into the input register, decoded against the lexer
// state once the queue has room for two tokens, and its zero, one or two
// tokens are written to a four-entry output queue. One byte per cycle
// while tokens drain as fast.
// src_stall rises only when a byte waits in the input register and the
// queue has fewer than two free entries; tok_stall backs up into it.
// Reset clears the lexer to idle at position 0 and empties the queue.
`include "shell_token_lexer_core_defines.svh"

module shell_token_lexer_core #(
	parameter int unsigned POS_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  shtl_pkg::src_word_t src_word,
	output logic                tok_valid,
	input  logic                tok_stall,
	output shtl_pkg::tok_word_t tok_word
);

	logic                valid_s1;
	shtl_pkg::src_word_t word_s1;
	logic                room, fire;
	shtl_pkg::lex_res_t  res, push;

	// Decode the held byte once the queue can take its tokens.
	assign fire      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	// Payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_word;
		end
	end

	shtl_lex #(
		.POS_WIDTH(POS_WIDTH)
	) u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (fire),
		.item   (word_s1),
		.res    (res)
	);

	// Drop the decode result unless the byte is consumed this cycle.
	always_comb begin
		push = res;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	shtl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_word  (tok_word)
	);

	`SHTL_ASSERT_NEXT(a_top_accept_loads, src_valid && !src_stall, valid_s1,
		"accepted byte missing from input register")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the streaming shell token lexer.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned POS_W = 16;
	localparam longint unsigned POS_TOP = (64'd1 << POS_W) - 1;
	localparam int unsigned HANG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Lexer modes of the predictor.
	typedef enum logic [2:0] {
		LX_IDLE,
		LX_WORD,
		LX_AMP,
		LX_PIPE,
		LX_HALT
	} lex_state_t;

	logic                clk;
	logic                arst_n;
	logic                src_valid;
	logic                src_stall;
	shtl_pkg::src_word_t src_word;
	logic                tok_valid;
	logic                tok_stall;
	shtl_pkg::tok_word_t tok_word;

	shell_token_lexer_core #(
		.POS_WIDTH(POS_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_word (tok_word)
	);

	// Predictor state: mirrors the lexer position, open token and mode.
	lex_state_t          lx_state;
	longint unsigned     lx_pos;
	longint unsigned     lx_begin;
	shtl_pkg::tok_word_t token_q[$];  // tokens still owed by the lexer, oldest first
	int                  live_bytes;  // bytes taken while the lexer was not halted

	int  fails;
	int  idle_cycles;
	int  stall_run;
	bit  calm;  // when set, neither side inserts gaps or stalls

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------

	function automatic bit is_blank(logic [7:0] b);
		return b == shtl_pkg::CH_SPACE || (b >= shtl_pkg::CH_TAB && b <= shtl_pkg::CH_CR);
	endfunction

	function automatic bit is_delim(logic [7:0] b);
		return is_blank(b) || b == shtl_pkg::CH_SEMI || b == shtl_pkg::CH_LPAREN ||
			b == shtl_pkg::CH_RPAREN || b == shtl_pkg::CH_AMP || b == shtl_pkg::CH_PIPE;
	endfunction

	function automatic void restart_lexer();
		lx_state = LX_IDLE;
		lx_pos   = 0;
		lx_begin = 0;
	endfunction

	// Position counter sticks at its top value.
	function automatic void advance_pos();
		if (lx_pos < POS_TOP)
			lx_pos++;
	endfunction

	function automatic void add_token(shtl_pkg::tok_kind_t k, longint unsigned s,
			longint unsigned e);
		shtl_pkg::tok_word_t t;
		longint unsigned     len;
		len = (e > s) ? e - s : 0;
		if (len > shtl_pkg::LEN_MAX)
			len = shtl_pkg::LEN_MAX;
		t.token_kind   = k;
		t.token_pos    = s[shtl_pkg::FIELD_W-1:0];
		t.token_length = len[shtl_pkg::FIELD_W-1:0];
		t.last_of_item = 1'b0;
		token_q.push_back(t);
	endfunction

	// Byte seen while no token is open.
	function automatic void open_token(logic [7:0] b, bit fin);
		longint unsigned s;
		if (fin) begin
			add_token(shtl_pkg::TK_END, lx_pos, lx_pos);
			restart_lexer();
		end else if (is_blank(b)) begin
			advance_pos();
		end else if (b == shtl_pkg::CH_SEMI || b == shtl_pkg::CH_LPAREN ||
				b == shtl_pkg::CH_RPAREN) begin
			s = lx_pos;
			advance_pos();
			add_token((b == shtl_pkg::CH_SEMI) ? shtl_pkg::TK_SEMI :
				(b == shtl_pkg::CH_LPAREN) ? shtl_pkg::TK_LPAREN : shtl_pkg::TK_RPAREN,
				s, lx_pos);
		end else begin
			lx_begin = lx_pos;
			lx_state = (b == shtl_pkg::CH_AMP) ? LX_AMP :
				(b == shtl_pkg::CH_PIPE) ? LX_PIPE : LX_WORD;
			advance_pos();
		end
	endfunction

	function automatic void predict_tokens(shtl_pkg::src_word_t w);
		bit         fin;
		int         n0;
		logic [7:0] want;
		fin = w.end_of_source || w.ch == shtl_pkg::CH_NUL;
		n0  = token_q.size();
		if (lx_state != LX_HALT)
			live_bytes++;
		case (lx_state)
			LX_HALT: begin
				if (fin)
					restart_lexer();
			end
			LX_WORD: begin
				if (!fin && !is_delim(w.ch)) begin
					advance_pos();
				end else begin
					add_token(shtl_pkg::TK_WORD, lx_begin, lx_pos);
					lx_state = LX_IDLE;
					open_token(w.ch, fin);
				end
			end
			LX_AMP, LX_PIPE: begin
				want = (lx_state == LX_AMP) ? shtl_pkg::CH_AMP : shtl_pkg::CH_PIPE;
				if (!fin && w.ch == want) begin
					advance_pos();
					add_token((lx_state == LX_AMP) ? shtl_pkg::TK_ANDAND : shtl_pkg::TK_OROR,
						lx_begin, lx_pos);
					lx_state = LX_IDLE;
				end else begin
					// lone operator: one-byte bad token, then skip to end of source
					add_token(shtl_pkg::TK_BAD, lx_begin, lx_begin + 1);
					if (fin)
						restart_lexer();
					else
						lx_state = LX_HALT;
				end
			end
			default: begin
				lx_state = LX_IDLE;
				open_token(w.ch, fin);
			end
		endcase
		if (token_q.size() > n0)
			token_q[token_q.size()-1].last_of_item = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Random helpers
	// ---------------------------------------------------------------

	// Mostly no gap, some short ones, a few long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (is_delim(b));
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? shtl_pkg::CH_SPACE : 8'(shtl_pkg::CH_TAB + r);
	endfunction

	function automatic logic [7:0] punct_byte();
		case ($urandom_range(0, 2))
			0: return shtl_pkg::CH_SEMI;
			1: return shtl_pkg::CH_LPAREN;
			default: return shtl_pkg::CH_RPAREN;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Source side: present one word, hold it until taken, predict its tokens
	// ---------------------------------------------------------------

	task automatic send_byte(input logic [7:0] c, input logic eos);
		int                  gap;
		shtl_pkg::src_word_t w;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.ch            = c;
		w.end_of_source = eos;
		src_valid <= 1'b1;
		src_word  <= w;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		predict_tokens(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// ---------------------------------------------------------------
	// Token side: random stall, in runs, off while calm
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || calm) begin
			tok_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
		end else if ($urandom_range(0, 3) == 0) begin
			tok_stall <= 1'b1;
			stall_run = gap_len();
		end else begin
			tok_stall <= 1'b0;
			stall_run = $urandom_range(0, 12);
		end
	end

	// Compare every taken token against the oldest prediction.
	always @(posedge clk) begin : check_tokens
		shtl_pkg::tok_word_t want_tok;
		if (arst_n && tok_valid && !tok_stall) begin
			if (token_q.size() == 0) begin
				$error("unexpected token: kind %0d pos %0d length %0d",
					tok_word.token_kind, tok_word.token_pos, tok_word.token_length);
				fails++;
			end else begin
				want_tok = token_q.pop_front();
				if (tok_word.token_kind !== want_tok.token_kind) begin
					$error("token_kind: expected %0d, got %0d",
						want_tok.token_kind, tok_word.token_kind);
					fails++;
				end
				if (tok_word.token_pos !== want_tok.token_pos) begin
					$error("token_pos: expected %0d, got %0d",
						want_tok.token_pos, tok_word.token_pos);
					fails++;
				end
				if (tok_word.token_length !== want_tok.token_length) begin
					$error("token_length: expected %0d, got %0d",
						want_tok.token_length, tok_word.token_length);
					fails++;
				end
				if (tok_word.last_of_item !== want_tok.last_of_item) begin
					$error("last_of_item: expected %0d, got %0d",
						want_tok.last_of_item, tok_word.last_of_item);
					fails++;
				end
			end
		end
	end

	// Hang detection: too long with no word moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("shell_token_lexer_core test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Every token kind but the bad token, all blank bytes, high bytes, two tokens from one byte,
	// both ways to end a source.
	task automatic test_basic_tokens();
		send_text("ab \t");
		send_byte(shtl_pkg::CH_CR, 1'b0);
		send_text("\n\v\f;()&&||");
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text(";q&&w(x");
		send_byte(shtl_pkg::CH_AMP, 1'b1);  // end mark ignores the byte value
		send_byte(shtl_pkg::CH_SEMI, 1'b0);
		send_byte(shtl_pkg::CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b1);   // end with nothing open
	endtask

	// Lone '&' and '|': bad token, skip to end, no end token.
	task automatic test_lone_operators();
		send_text("&x&&y;");
		send_byte(shtl_pkg::CH_NUL, 1'b1);
		send_byte(shtl_pkg::CH_PIPE, 1'b0);
		send_byte(shtl_pkg::CH_NUL, 1'b0);   // end right after the lone byte
		send_text("&||");
		send_byte(shtl_pkg::CH_NUL, 1'b0);
		send_text("ab| ");
		send_byte(shtl_pkg::CH_PIPE, 1'b0);
		send_byte(shtl_pkg::CH_PIPE, 1'b1);
		send_byte(shtl_pkg::CH_AMP, 1'b0);
		send_byte(shtl_pkg::CH_NUL, 1'b1);
	endtask

	// Mostly well-formed sources with random content, some noise and
	// broken operators.
	task automatic test_random_sources(input int n_bytes);
		int         goal;
		int         r;
		logic [7:0] c;
		goal = live_bytes + n_bytes;
		while (live_bytes < goal) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				repeat ($urandom_range(1, 6))
					send_byte(word_byte(), 1'b0);
			end else if (r < 53) begin
				repeat ($urandom_range(1, 3))
					send_byte(blank_byte(), 1'b0);
			end else if (r < 68) begin
				send_byte(punct_byte(), 1'b0);
			end else if (r < 80) begin
				c = $urandom_range(0, 1) ? shtl_pkg::CH_AMP : shtl_pkg::CH_PIPE;
				send_byte(c, 1'b0);
				send_byte(c, 1'b0);
			end else if (r < 84) begin
				c = $urandom_range(0, 1) ? shtl_pkg::CH_AMP : shtl_pkg::CH_PIPE;
				send_byte(c, 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if ($urandom_range(0, 1)) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_byte(shtl_pkg::CH_NUL, 1'b0);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		src_valid  = 1'b0;
		src_word   = '0;
		tok_stall  = 1'b0;
		fails      = 0;
		live_bytes = 0;
		calm       = 1'b0;
		restart_lexer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_tokens();
		test_lone_operators();
		test_random_sources(1100);

		// Drop valid, let the owed tokens drain, then watch for strays.
		src_valid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("shell_token_lexer_core test passed");
		else
			$display("shell_token_lexer_core test failed");
		$finish;
	end

endmodule
